@@ rtl/core/tsgd_pkg.sv @@
// ----------------------------------------------------------------------------
// tsgd_pkg
// Shared constants, types and helpers for the token sequence diff unit.
// ----------------------------------------------------------------------------
package tsgd_pkg;

   localparam int MaxLen      = 256;
   localparam int MaxEdits    = 128;
   localparam int TokenBits   = 16;
   localparam int StoreDepth  = (MaxEdits + 1) * (MaxEdits + 2) / 2;
   localparam int LenW        = 9;    // counts 0..256
   localparam int AddrW       = 8;    // token memory index
   localparam int StoreAw     = $clog2(StoreDepth);
   localparam int DiagW       = 11;   // signed diagonal / edit count
   localparam int MaxGroups   = 4;

   typedef enum logic [1:0] {
      KIND_REF   = 2'd0,
      KIND_GEN   = 2'd1,
      KIND_START = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ROW, ST_DIAG, ST_PRED1, ST_PRED2, ST_PICK, ST_SNAKE_RD, ST_SNAKE_CMP,
      ST_PUT, ST_BT_INIT, ST_BT_F, ST_BT_P1, ST_BT_P2, ST_BT_PICK, ST_BT_MARK,
      ST_OUT, ST_OUT_WAIT
   } state_type;

   // row_base(p) = p*(p+1)/2
   function automatic logic [StoreAw-1:0] row_base(input logic [DiagW-1:0] p);
      logic [2*DiagW-1:0] prod;
      prod = {{DiagW{1'b0}}, p} * {{DiagW{1'b0}}, (p + 1'b1)};
      return StoreAw'(prod >> 1);
   endfunction

endpackage

@@ rtl/core/token_sequence_greedy_diff_unit.sv @@
// ----------------------------------------------------------------------------
// token_sequence_greedy_diff_unit
// Greedy insert/delete diff of two token streams with matched-token report.
// ----------------------------------------------------------------------------
// Reference (kind 0) and generated (kind 1) tokens load one per cycle while the
// unit is idle. A start item (kind 2) runs the greedy shortest-edit walk under a
// small sequencer that drives one shared compare path and one reach store port:
// each row steps through its diagonals and skips pruned ones; a walked diagonal
// reads both predecessors, picks one, follows the matching snake and writes its
// reach; backtracking reads each row's reach and predecessors, then marks the
// matched tokens. Reach rows are written before they are read, so the store
// needs no clearing. Results leave after ST_OUT as one to four items of 64
// flags; req_tready is low from the start item until the last result is taken.
module token_sequence_greedy_diff_unit
   import tsgd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // token[15:0]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // group_index[1:0], match_flags[65:2], edit_count[75:66]
   output logic        rsp_tuser,   // overflow
   output logic        rsp_tlast    // last_group
);

   // memories
   logic [TokenBits-1:0] ref_mem [MaxLen];
   logic [TokenBits-1:0] gen_mem [MaxLen];
   logic [LenW-1:0]      store_mem [StoreDepth];

   state_type state_ff, state_in;
   logic [LenW-1:0]  ref_cnt_ff, gen_cnt_ff;
   logic signed [DiagW-1:0] p_ff, k_ff, lo_ff, hi_ff, from_ff;
   logic [LenW-1:0]  i_ff, a_ff, f_ff;
   logic [MaxLen-1:0] marks_ff;
   logic              ok_ff;
   logic [1:0]        grp_ff;
   logic [LenW-1:0]   rd_ff;
   logic              rv_ff;
   logic [TokenBits-1:0] rt_ff, gt_ff;

   logic accept, out_fire;
   assign accept   = req_tvalid && req_tready;
   assign out_fire = rsp_tvalid && rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // load path
   always_ff @(posedge clock) begin
      if (accept && req_tuser == KIND_REF && ref_cnt_ff != LenW'(MaxLen))
         ref_mem[ref_cnt_ff[AddrW-1:0]] <= req_tdata[TokenBits-1:0];
      if (accept && req_tuser == KIND_GEN && gen_cnt_ff != LenW'(MaxLen))
         gen_mem[gen_cnt_ff[AddrW-1:0]] <= req_tdata[TokenBits-1:0];
   end

   // store address: row_base(q)+(k+q)/2
   logic signed [DiagW-1:0] rq, rk, rt;
   logic rvalid;
   logic [StoreAw-1:0] raddr;
   logic signed [DiagW-1:0] m_s, n_s, j_s;
   assign m_s = DiagW'($signed({2'b0, ref_cnt_ff}));
   assign n_s = DiagW'($signed({2'b0, gen_cnt_ff}));
   assign j_s = DiagW'($signed({2'b0, i_ff})) + k_ff;

   always_comb begin
      rq = p_ff - 1'b1;
      rk = k_ff - 1'b1;
      unique case (state_ff)
         ST_PRED2, ST_BT_P2: rk = k_ff + 1'b1;
         ST_PUT, ST_BT_F: begin rq = p_ff; rk = k_ff; end
         default: ;
      endcase
      rt = rk + rq;
      rvalid = (rq >= 0) && (rt >= 0) && (rt <= (rq <<< 1));
      raddr = row_base(rq) + StoreAw'(rt >>> 1);
   end

   logic snake_go;
   assign snake_go = (i_ff < ref_cnt_ff) && (j_s >= 0) && (j_s < n_s);

   // store and token reads; the in-row flag follows the read data
   always_ff @(posedge clock) begin
      if (state_ff == ST_PUT && rvalid) store_mem[raddr] <= i_ff;
      rd_ff <= store_mem[raddr];
      rv_ff <= rvalid;
      rt_ff <= ref_mem[i_ff[AddrW-1:0]];
      gt_ff <= gen_mem[j_s[AddrW-1:0]];
   end

   logic [LenW-1:0] pred;
   assign pred = rv_ff ? rd_ff : '0;
   logic [LenW-1:0] groups;
   assign groups = (ref_cnt_ff == 0) ? LenW'(1) :
                   (ref_cnt_ff > LenW'(192)) ? LenW'(MaxGroups) :
                   ((ref_cnt_ff + LenW'(63)) >> 6);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept && req_tuser == KIND_START) state_in = ST_ROW;
         ST_ROW:    if (lo_ff > n_s - m_s) state_in = ST_BT_INIT;
                    else if (p_ff == DiagW'(MaxEdits)) state_in = ST_OUT;
                    else state_in = ST_DIAG;
         ST_DIAG:   if (k_ff > p_ff) state_in = ST_ROW;
                    else if (k_ff < lo_ff || k_ff > hi_ff) state_in = ST_DIAG;
                    else state_in = ST_PRED1;
         ST_PRED1:  state_in = ST_PRED2;
         ST_PRED2:  state_in = ST_PICK;
         ST_PICK:   state_in = ST_SNAKE_RD;
         ST_SNAKE_RD: state_in = snake_go ? ST_SNAKE_CMP : ST_PUT;
         ST_SNAKE_CMP: state_in = (rt_ff == gt_ff) ? ST_SNAKE_RD : ST_PUT;
         ST_PUT:    state_in = ST_DIAG;
         ST_BT_INIT: state_in = ST_BT_F;
         ST_BT_F:   state_in = ST_BT_P1;
         ST_BT_P1:  state_in = ST_BT_P2;
         ST_BT_P2:  state_in = ST_BT_PICK;
         ST_BT_PICK: state_in = ST_BT_MARK;
         ST_BT_MARK: if (f_ff <= a_ff) state_in = (p_ff == 0) ? ST_OUT : ST_BT_F;
         ST_OUT:    state_in = ST_OUT_WAIT;
         ST_OUT_WAIT: if (out_fire && LenW'(grp_ff) + 1'b1 == groups) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath registers
   logic [LenW-1:0] v2;
   logic [LenW-1:0] f_dec;
   logic signed [DiagW-1:0] pp;
   assign pp = p_ff - 1'b1;
   assign v2 = pred + 1'b1;
   assign f_dec = f_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ref_cnt_ff <= '0;
         gen_cnt_ff <= '0;
         grp_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept && req_tuser == KIND_REF && ref_cnt_ff != LenW'(MaxLen))
            ref_cnt_ff <= ref_cnt_ff + 1'b1;
         if (accept && req_tuser == KIND_GEN && gen_cnt_ff != LenW'(MaxLen))
            gen_cnt_ff <= gen_cnt_ff + 1'b1;
         if (state_ff == ST_OUT) grp_ff <= '0;
         if (state_ff == ST_OUT_WAIT && out_fire) begin
            grp_ff <= grp_ff + 1'b1;
            if (state_in == ST_IDLE) begin
               ref_cnt_ff <= '0;
               gen_cnt_ff <= '0;
            end
         end
      end
      unique case (state_ff)
         ST_IDLE: begin
            p_ff <= -11'sd1; lo_ff <= -m_s; hi_ff <= n_s;
            marks_ff <= '0; ok_ff <= 1'b1;
         end
         ST_ROW: begin
            if (!(lo_ff > n_s - m_s)) begin
               if (p_ff == DiagW'(MaxEdits)) ok_ff <= 1'b0;
               p_ff <= p_ff + 1'b1;
               k_ff <= -(p_ff + 1'b1);
            end
         end
         ST_DIAG: if (k_ff < lo_ff || k_ff > hi_ff) k_ff <= k_ff + 11'sd2;
         ST_PRED1: a_ff <= '0;
         ST_PRED2: a_ff <= (k_ff > -pp && p_ff > 0) ? pred : '0;
         ST_PICK: i_ff <= (k_ff < pp && p_ff > 0 && v2 >= a_ff) ? v2 : a_ff;
         ST_SNAKE_CMP: if (rt_ff == gt_ff) i_ff <= i_ff + 1'b1;
         ST_PUT: begin
            if (i_ff == ref_cnt_ff) lo_ff <= k_ff + 1'b1;
            if (j_s == n_s) hi_ff <= k_ff - 1'b1;
            k_ff <= k_ff + 11'sd2;
         end
         ST_BT_INIT: k_ff <= n_s - m_s;
         ST_BT_F: ;
         ST_BT_P1: f_ff <= pred;
         ST_BT_P2: begin
            if (k_ff > -pp && p_ff > 0) begin
               a_ff <= pred; from_ff <= k_ff - 1'b1;
            end else begin
               a_ff <= '0; from_ff <= k_ff;
            end
         end
         ST_BT_PICK: if (k_ff < pp && p_ff > 0 && v2 >= a_ff) begin
            a_ff <= v2; from_ff <= k_ff + 1'b1;
         end
         ST_BT_MARK: begin
            if (f_ff > a_ff) begin
               f_ff <= f_dec;
               if (f_dec < ref_cnt_ff) marks_ff[f_dec[AddrW-1:0]] <= 1'b1;
            end else if (p_ff != 0) begin
               k_ff <= from_ff;
               p_ff <= p_ff - 1'b1;
            end
         end
         default: ;
      endcase
   end

   // edit count is latched as walk depth before backtracking shrinks p
   logic [9:0] edits_ff;
   always_ff @(posedge clock)
      if (state_ff == ST_BT_INIT) edits_ff <= p_ff[9:0];

   // result item
   logic [63:0] flags;
   always_comb begin
      flags = '0;
      for (int b = 0; b < 64; b++)
         flags[b] = ok_ff && marks_ff[{grp_ff, 6'(b)}] &&
                    ({1'b0, grp_ff, 6'(b)} < ref_cnt_ff);
   end
   assign rsp_tvalid = (state_ff == ST_OUT_WAIT);
   assign rsp_tdata  = {4'b0, ok_ff ? edits_ff : 10'd0, flags, grp_ff};
   assign rsp_tuser  = !ok_ff;
   assign rsp_tlast  = (LenW'(grp_ff) + 1'b1 == groups);

endmodule
